FILE: src/rpr_pkg.sv
package rpr_pkg;

    // field widths
    localparam int IDX_W   = 13;
    localparam int POS_W   = 12;
    localparam int HS_W    = 9;
    localparam int KV_W    = 14;
    localparam int DATA_W  = 32;
    localparam int ANGLE_W = 43;
    localparam int Z_W     = 35;

    // clamps
    localparam int DIM_MAX = 8192;
    localparam int SEQ_MAX = 4096;

    // configuration register indexes
    localparam logic [7:0] CFG_HSIZE  = 8'd0;
    localparam logic [7:0] CFG_KV_DIM = 8'd1;

    // fixed-point constants, Q30
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic [33:0] LOG2_10000_Q30 = 34'd14267572527;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [32:0] TWO_PI_U_Q30   = 33'd6746518852;
    localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [Z_W-1:0] CORDIC_GAIN_Q30 = 35'sd652032874;

    localparam int CORDIC_STEPS = 30;
    localparam int EXP_TERMS    = 12;

    // pipeline depths
    localparam int FREQ_LAT   = 74;
    localparam int CORDIC_LAT = 42;
    localparam int LANE_LAT   = 2;

    // ceil(2^34 / k) for exact floor division of a 30-bit value by k
    localparam logic [33:0] EXP_RECIP [0:12] = '{
        34'd0, 34'd0, 34'd8589934592, 34'd5726623062, 34'd4294967296,
        34'd3435973837, 34'd2863311531, 34'd2454267027, 34'd2147483648,
        34'd1908874354, 34'd1717986919, 34'd1561806290, 34'd1431655766
    };

    localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic [IDX_W-1:0]         elem_index;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] q_even;
        logic signed [DATA_W-1:0] q_odd;
        logic signed [DATA_W-1:0] k_even;
        logic signed [DATA_W-1:0] k_odd;
    } rpr_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] q_even_rot;
        logic signed [DATA_W-1:0] q_odd_rot;
        logic signed [DATA_W-1:0] k_even_rot;
        logic signed [DATA_W-1:0] k_odd_rot;
        logic                     key_rotated;
    } rpr_out_t;

endpackage

FILE: src/rpr_freq.sv
module rpr_freq (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [rpr_pkg::HS_W-1:0]          hsize,
    input  logic [rpr_pkg::IDX_W-1:0]         elem_index,
    input  logic [rpr_pkg::POS_W-1:0]         position,
    output logic [rpr_pkg::ANGLE_W-1:0]       angle
);

    // one restoring division step: {quotient bit, remainder}
    function automatic logic [9:0] div_step(input logic [8:0] r, input logic b,
                                            input logic [8:0] d);
        logic [9:0] trial;
        logic [9:0] diff;
        trial = {r, b};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            div_step = {1'b1, diff[8:0]};
        end else begin
            div_step = {1'b0, trial[8:0]};
        end
    endfunction

    logic       hs_zero;
    assign hs_zero = (hsize == '0);

    // position travels alongside the whole chain
    logic [rpr_pkg::POS_W-1:0] pos_reg [0:72];

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= position;
            for (int i = 1; i < 73; i++) begin
                pos_reg[i] <= pos_reg[i-1];
            end
        end
    end

    // d = elem_index mod head size, one bit a stage
    logic [8:0]  md_rem_reg [0:12];
    logic [12:0] md_idx_reg [0:12];
    logic [9:0]  md_step    [0:12];

    always_comb begin
        md_step[0] = div_step(9'd0, elem_index[12], hsize);
        for (int k = 1; k < 13; k++) begin
            md_step[k] = div_step(md_rem_reg[k-1], md_idx_reg[k-1][12-k], hsize);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            md_idx_reg[0] <= elem_index;
            for (int k = 0; k < 13; k++) begin
                md_rem_reg[k] <= md_step[k][8:0];
            end
            for (int k = 1; k < 13; k++) begin
                md_idx_reg[k] <= md_idx_reg[k-1];
            end
        end
    end

    // scale d by log2(10000)
    logic [42:0] dl_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg <= 43'(md_rem_reg[12]) * 43'(rpr_pkg::LOG2_10000_Q30);
        end
    end

    // exponent e = dl / head size, 34 quotient bits
    logic [8:0]  ed_rem_reg [0:33];
    logic [33:0] ed_quo_reg [0:33];
    logic [33:0] ed_dl_reg  [0:33];
    logic [9:0]  ed_step    [0:33];

    always_comb begin
        ed_step[0] = div_step(dl_reg[42:34], dl_reg[33], hsize);
        for (int j = 1; j < 34; j++) begin
            ed_step[j] = div_step(ed_rem_reg[j-1], ed_dl_reg[j-1][33-j], hsize);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ed_dl_reg[0]  <= dl_reg[33:0];
            ed_quo_reg[0] <= {33'd0, ed_step[0][9]};
            for (int j = 0; j < 34; j++) begin
                ed_rem_reg[j] <= ed_step[j][8:0];
            end
            for (int j = 1; j < 34; j++) begin
                ed_dl_reg[j]  <= ed_dl_reg[j-1];
                ed_quo_reg[j] <= {ed_quo_reg[j-1][32:0], ed_step[j][9]};
            end
        end
    end

    // split exponent, scale fraction by ln 2
    logic [59:0] xprod;
    logic [29:0] x_reg;
    logic [3:0]  n_reg;

    assign xprod = 60'(ed_quo_reg[33][29:0]) * 60'(rpr_pkg::LN2_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= xprod[59:30];
            n_reg <= ed_quo_reg[33][33:30];
        end
    end

    // exp(-x) by Horner, two stages a term
    logic [29:0] p_reg  [0:11];
    logic [30:0] t_reg  [0:11];
    logic [29:0] xa_reg [0:11];
    logic [29:0] xb_reg [0:11];
    logic [3:0]  na_reg [0:11];
    logic [3:0]  nb_reg [0:11];
    logic [30:0] t_src  [0:11];
    logic [29:0] x_src  [0:11];
    logic [3:0]  n_src  [0:11];
    logic [60:0] pprod  [0:11];
    logic [63:0] qprod  [0:11];
    logic [29:0] qv     [0:11];

    always_comb begin
        t_src[0] = rpr_pkg::ONE_Q30;
        x_src[0] = x_reg;
        n_src[0] = n_reg;
        for (int i = 1; i < 12; i++) begin
            t_src[i] = t_reg[i-1];
            x_src[i] = xb_reg[i-1];
            n_src[i] = nb_reg[i-1];
        end
        for (int i = 0; i < 12; i++) begin
            pprod[i] = 61'(x_src[i]) * 61'(t_src[i]);
            qprod[i] = 64'(p_reg[i]) * 64'(rpr_pkg::EXP_RECIP[12-i]);
            qv[i]    = (i == 11) ? p_reg[i] : qprod[i][63:34];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 12; i++) begin
                p_reg[i]  <= pprod[i][59:30];
                xa_reg[i] <= x_src[i];
                na_reg[i] <= n_src[i];
                t_reg[i]  <= rpr_pkg::ONE_Q30 - 31'(qv[i]);
                xb_reg[i] <= xa_reg[i];
                nb_reg[i] <= na_reg[i];
            end
        end
    end

    // freq = t >> n (one when head size is zero), angle = position * freq
    logic [30:0] freq;
    logic [rpr_pkg::ANGLE_W-1:0] angle_reg;

    assign freq = hs_zero ? rpr_pkg::ONE_Q30 : (t_reg[11] >> nb_reg[11]);

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= 43'(pos_reg[72]) * 43'(freq);
        end
    end

    assign angle = angle_reg;

endmodule

FILE: src/rpr_cordic.sv
module rpr_cordic (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [rpr_pkg::ANGLE_W-1:0]       angle,
    output logic signed [rpr_pkg::DATA_W-1:0] cos_q30,
    output logic signed [rpr_pkg::DATA_W-1:0] sin_q30
);

    localparam int ZW = rpr_pkg::Z_W;
    localparam int NS = rpr_pkg::CORDIC_STEPS;

    // reduce modulo 2*pi, one power-of-two multiple a stage
    logic [42:0] rd_reg [0:9];
    logic [42:0] rd_src [0:9];
    logic [42:0] rd_cst [0:9];

    always_comb begin
        rd_src[0] = angle;
        for (int i = 1; i < 10; i++) begin
            rd_src[i] = rd_reg[i-1];
        end
        for (int i = 0; i < 10; i++) begin
            rd_cst[i] = 43'(rpr_pkg::TWO_PI_U_Q30) << (9 - i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 10; i++) begin
                rd_reg[i] <= (rd_src[i] >= rd_cst[i]) ? rd_src[i] - rd_cst[i] : rd_src[i];
            end
        end
    end

    // fold into [-pi/2, pi/2]
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] z1;
    logic signed [ZW-1:0] zf_next;
    logic                 negf_next;
    logic signed [ZW-1:0] zf_reg;
    logic                 negf_reg;

    always_comb begin
        z0 = signed'({2'b00, rd_reg[9][32:0]});
        z1 = (z0 > rpr_pkg::PI_Q30) ? z0 - rpr_pkg::TWO_PI_Q30 : z0;
        zf_next   = z1;
        negf_next = 1'b0;
        if (z1 > rpr_pkg::HALF_PI_Q30) begin
            zf_next   = z1 - rpr_pkg::PI_Q30;
            negf_next = 1'b1;
        end else if (z1 < -rpr_pkg::HALF_PI_Q30) begin
            zf_next   = z1 + rpr_pkg::PI_Q30;
            negf_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg   <= zf_next;
            negf_reg <= negf_next;
        end
    end

    // rotation steps
    logic signed [ZW-1:0] cx_reg [0:NS-1];
    logic signed [ZW-1:0] cy_reg [0:NS-1];
    logic signed [ZW-1:0] cz_reg [0:NS-1];
    logic                 cn_reg [0:NS-1];
    logic signed [ZW-1:0] x_src  [0:NS-1];
    logic signed [ZW-1:0] y_src  [0:NS-1];
    logic signed [ZW-1:0] z_src  [0:NS-1];
    logic                 n_src  [0:NS-1];
    logic signed [ZW-1:0] x_nxt  [0:NS-1];
    logic signed [ZW-1:0] y_nxt  [0:NS-1];
    logic signed [ZW-1:0] z_nxt  [0:NS-1];

    always_comb begin
        x_src[0] = rpr_pkg::CORDIC_GAIN_Q30;
        y_src[0] = '0;
        z_src[0] = zf_reg;
        n_src[0] = negf_reg;
        for (int i = 1; i < NS; i++) begin
            x_src[i] = cx_reg[i-1];
            y_src[i] = cy_reg[i-1];
            z_src[i] = cz_reg[i-1];
            n_src[i] = cn_reg[i-1];
        end
        for (int i = 0; i < NS; i++) begin
            if (!z_src[i][ZW-1]) begin
                x_nxt[i] = x_src[i] - (y_src[i] >>> i);
                y_nxt[i] = y_src[i] + (x_src[i] >>> i);
                z_nxt[i] = z_src[i] - signed'(ZW'(rpr_pkg::ATAN_Q30[i]));
            end else begin
                x_nxt[i] = x_src[i] + (y_src[i] >>> i);
                y_nxt[i] = y_src[i] - (x_src[i] >>> i);
                z_nxt[i] = z_src[i] + signed'(ZW'(rpr_pkg::ATAN_Q30[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                cx_reg[i] <= x_nxt[i];
                cy_reg[i] <= y_nxt[i];
                cz_reg[i] <= z_nxt[i];
                cn_reg[i] <= n_src[i];
            end
        end
    end

    // undo the fold by pi
    logic signed [rpr_pkg::DATA_W-1:0] c_reg;
    logic signed [rpr_pkg::DATA_W-1:0] s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= 32'(cn_reg[NS-1] ? -cx_reg[NS-1] : cx_reg[NS-1]);
            s_reg <= 32'(cn_reg[NS-1] ? -cy_reg[NS-1] : cy_reg[NS-1]);
        end
    end

    assign cos_q30 = c_reg;
    assign sin_q30 = s_reg;

endmodule

FILE: src/rpr_lane.sv
module rpr_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [rpr_pkg::DATA_W-1:0] cos_q30,
    input  logic signed [rpr_pkg::DATA_W-1:0] sin_q30,
    input  logic signed [rpr_pkg::DATA_W-1:0] a_even,
    input  logic signed [rpr_pkg::DATA_W-1:0] a_odd,
    output logic signed [rpr_pkg::DATA_W-1:0] even_rot,
    output logic signed [rpr_pkg::DATA_W-1:0] odd_rot
);

    // round to Q16.16 and clamp to 32 bits
    function automatic logic signed [31:0] sat_round(input logic signed [65:0] acc);
        logic signed [65:0] sh;
        sh = (acc + 66'sd536870912) >>> 30;
        if (sh > 66'sd2147483647) begin
            sat_round = 32'sh7FFFFFFF;
        end else if (sh < -66'sd2147483648) begin
            sat_round = 32'sh80000000;
        end else begin
            sat_round = sh[31:0];
        end
    endfunction

    logic signed [63:0] ec_reg;
    logic signed [63:0] os_reg;
    logic signed [63:0] es_reg;
    logic signed [63:0] oc_reg;
    logic signed [31:0] even_reg;
    logic signed [31:0] odd_reg;

    // products
    always_ff @(posedge aclk) begin
        if (en) begin
            ec_reg <= 64'(a_even) * 64'(cos_q30);
            os_reg <= 64'(a_odd)  * 64'(sin_q30);
            es_reg <= 64'(a_even) * 64'(sin_q30);
            oc_reg <= 64'(a_odd)  * 64'(cos_q30);
        end
    end

    // sums, round, saturate
    always_ff @(posedge aclk) begin
        if (en) begin
            even_reg <= sat_round(66'(ec_reg) - 66'(os_reg));
            odd_reg  <= sat_round(66'(es_reg) + 66'(oc_reg));
        end
    end

    assign even_rot = even_reg;
    assign odd_rot  = odd_reg;

endmodule

FILE: src/rotary_position_rotator.sv
// Rotary position embedding for one query/key element pair.
// Input channel s_valid/s_ready/s_data carries the element index, token
// position and the Q16.16 query and key pairs; result channel
// m_valid/m_ready/m_data returns the rotated pairs and key_rotated.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// head size (index 0) and kv_dim (index 1); cfg_ready is always high and
// writes belong to idle periods. Other indexes are dropped.
// From input acceptance to m_valid a word passes through frequency
// generation (remainder and exponent dividers, one quotient bit a stage,
// then a two-stage-per-term exp series), range reduction and CORDIC, the
// query and key lanes, and the output word register.
// One word per cycle is accepted and delivered while the output is not stalled.
// Reset returns head size to 64, kv_dim to 4096 and empties the pipeline.
// When the receiver stalls, the output word holds; the pipeline keeps
// accepting until a finished word reaches its last stage, then s_ready drops
// until the output word is taken.
module rotary_position_rotator (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rpr_pkg::rpr_in_t         s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rpr_pkg::rpr_out_t        m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [7:0]               cfg_index,
    input  logic [15:0]              cfg_data
);

    localparam int LAT    = rpr_pkg::FREQ_LAT + rpr_pkg::CORDIC_LAT + rpr_pkg::LANE_LAT;
    localparam int CS_TAP = rpr_pkg::FREQ_LAT + rpr_pkg::CORDIC_LAT - 1;

    typedef struct packed {
        logic                             rot;
        logic signed [rpr_pkg::DATA_W-1:0] q_even;
        logic signed [rpr_pkg::DATA_W-1:0] q_odd;
        logic signed [rpr_pkg::DATA_W-1:0] k_even;
        logic signed [rpr_pkg::DATA_W-1:0] k_odd;
    } side_t;

    // configuration registers
    logic [rpr_pkg::HS_W-1:0] hsize_reg;
    logic [rpr_pkg::KV_W-1:0] kv_dim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hsize_reg  <= 9'd64;
            kv_dim_reg <= 14'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                rpr_pkg::CFG_HSIZE:  hsize_reg  <= cfg_data[8:0];
                rpr_pkg::CFG_KV_DIM: kv_dim_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: stop only when a finished word cannot leave
    logic             adv;
    logic [LAT-1:0]   vld_reg;
    side_t            sd_reg [0:LAT-1];
    side_t            sd_in;
    logic             m_valid_reg;
    rpr_pkg::rpr_out_t m_data_reg;

    assign adv     = ~(vld_reg[LAT-1] & m_valid_reg & ~m_ready);
    assign s_ready = adv;

    // clamp position and kv_dim, decide key rotation
    logic [rpr_pkg::POS_W-1:0] pos_clamp;
    logic [rpr_pkg::KV_W-1:0]  kv_eff;

    assign pos_clamp = ({1'b0, s_data.position} >= 13'(rpr_pkg::SEQ_MAX)) ?
                       12'(rpr_pkg::SEQ_MAX - 1) : s_data.position;
    assign kv_eff    = (kv_dim_reg > 14'(rpr_pkg::DIM_MAX)) ?
                       14'(rpr_pkg::DIM_MAX) : kv_dim_reg;

    always_comb begin
        sd_in.rot    = (14'(s_data.elem_index) < kv_eff);
        sd_in.q_even = s_data.q_even;
        sd_in.q_odd  = s_data.q_odd;
        sd_in.k_even = s_data.k_even;
        sd_in.k_odd  = s_data.k_odd;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // side payload alongside the angle chain
    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= sd_in;
            for (int i = 1; i < LAT; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // angle, then sine and cosine
    logic [rpr_pkg::ANGLE_W-1:0]       angle;
    logic signed [rpr_pkg::DATA_W-1:0] cos_q30;
    logic signed [rpr_pkg::DATA_W-1:0] sin_q30;

    rpr_freq u_freq (
        .aclk       (aclk),
        .en         (adv),
        .hsize      (hsize_reg),
        .elem_index (s_data.elem_index),
        .position   (pos_clamp),
        .angle      (angle)
    );

    rpr_cordic u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .angle   (angle),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // query and key lanes
    logic signed [rpr_pkg::DATA_W-1:0] q_even_rot;
    logic signed [rpr_pkg::DATA_W-1:0] q_odd_rot;
    logic signed [rpr_pkg::DATA_W-1:0] k_even_rot;
    logic signed [rpr_pkg::DATA_W-1:0] k_odd_rot;

    rpr_lane u_lane_q (
        .aclk     (aclk),
        .en       (adv),
        .cos_q30  (cos_q30),
        .sin_q30  (sin_q30),
        .a_even   (sd_reg[CS_TAP].q_even),
        .a_odd    (sd_reg[CS_TAP].q_odd),
        .even_rot (q_even_rot),
        .odd_rot  (q_odd_rot)
    );

    rpr_lane u_lane_k (
        .aclk     (aclk),
        .en       (adv),
        .cos_q30  (cos_q30),
        .sin_q30  (sin_q30),
        .a_even   (sd_reg[CS_TAP].k_even),
        .a_odd    (sd_reg[CS_TAP].k_odd),
        .even_rot (k_even_rot),
        .odd_rot  (k_odd_rot)
    );

    // merge lanes into the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (vld_reg[LAT-1] & adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[LAT-1] & adv) begin
            m_data_reg.q_even_rot  <= q_even_rot;
            m_data_reg.q_odd_rot   <= q_odd_rot;
            m_data_reg.k_even_rot  <= sd_reg[LAT-1].rot ? k_even_rot : sd_reg[LAT-1].k_even;
            m_data_reg.k_odd_rot   <= sd_reg[LAT-1].rot ? k_odd_rot  : sd_reg[LAT-1].k_odd;
            m_data_reg.key_rotated <= sd_reg[LAT-1].rot;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a finished word in the last stage survives a stalled output
    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAT-1] && m_valid_reg && !m_ready) |=> vld_reg[LAT-1])
        else $error("last stage word dropped under stall");

    // indexes at or past the key dimension limit never rotate the key
    a_kv_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (14'(s_data.elem_index) >= 14'(rpr_pkg::DIM_MAX)))
        |=> !sd_reg[0].rot)
        else $error("key rotation flagged beyond key dimension limit");

    // kv_dim write lands
    a_kv_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == rpr_pkg::CFG_KV_DIM)
        |=> kv_dim_reg == $past(cfg_data[13:0]))
        else $error("kv_dim write lost");

endmodule
